### hdl/sbe_pkg.sv
package sbe_pkg;

    // field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int BIAS_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int TS_W     = 63;
    localparam int LIMIT_W  = 31;
    localparam int GAIN_W   = 16;
    localparam int FRAC_W   = 16;

    // configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam int DEFAULT_TABLE_ENTRIES = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_SEED    = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_BIAS_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRUST      = 2'd2;

    // reset values
    localparam logic [LIMIT_W-1:0] RST_BIAS_LIMIT = 31'd1000000;
    localparam logic [GAIN_W-1:0]  RST_GAIN       = 16'd6554;
    localparam logic [COUNT_W-1:0] RST_TRUST      = 16'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [BIAS_W-1:0]  bias;
        logic [COUNT_W-1:0] count;
        logic [TS_W-1:0]    last_seen;
    } t_entry;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

endpackage

### hdl/sbe_blend.sv
module sbe_blend (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic signed [sbe_pkg::BIAS_W-1:0]  i_prev,
    input  logic signed [sbe_pkg::BIAS_W-1:0]  i_offset,
    input  logic        [sbe_pkg::GAIN_W-1:0]  i_gain,
    output logic signed [sbe_pkg::BIAS_W-1:0]  o_bias
);
    import sbe_pkg::*;

    localparam int DIFF_W = BIAS_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int EXT_W  = PROD_W - BIAS_W - FRAC_W;
    localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [PROD_W-1:0] HALF_DN = HALF - PROD_W'(1);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] sum;
    logic        [PROD_W-1:0] rnd;

    assign diff = $signed({i_offset[BIAS_W-1], i_offset}) - $signed({i_prev[BIAS_W-1], i_prev});

    // product registered ahead of the rounding add
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= diff * $signed({1'b0, i_gain});
        end
    end

    assign sum = $signed({{EXT_W{i_prev[BIAS_W-1]}}, i_prev, {FRAC_W{1'b0}}}) + r_prod;

    // round half away from zero: a negative sum gets just under a half before the floor
    assign rnd    = $unsigned(sum) + (sum[PROD_W-1] ? HALF_DN : HALF);
    assign o_bias = $signed(rnd[FRAC_W +: BIAS_W]);

endmodule

### hdl/station_bias_ema_table.sv
// station bias table: a small associative table keyed by a 16-bit station code; each
// entry holds a smoothed lateness bias, a sample count and the last observe time, all
// packed into one word of a single-port-per-direction synchronous memory (read data
// registered). every request is handled one at a time: the sequencer scans the occupied
// entries with one memory read per cycle, compares keys the cycle after the read while
// tracking the entry with the fewest samples, then for an accepted observe or seed does
// one read-modify-write of the chosen entry. a rejected observe or seed and the unused
// operation go straight to the result; a query returns its result after the scan; an
// observe on an entry with samples passes the multiply state before the write. a finished
// result sits in an output register, so the next request is taken while it waits. no
// clearing pass is needed after reset: only entries below the fill count are ever read.
// configuration registers are written through the apb port at byte addresses 0 (bias
// limit), 4 (gain), 8 (trust threshold).
module station_bias_ema_table #(
    parameter int TABLE_ENTRIES = sbe_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic        [sbe_pkg::OP_W-1:0]     i_operation,
    input  logic        [sbe_pkg::KEY_W-1:0]    i_station_id,
    input  logic signed [sbe_pkg::BIAS_W-1:0]   i_offset_us,
    input  logic        [sbe_pkg::TS_W-1:0]     i_timestamp_us,
    input  logic        [sbe_pkg::COUNT_W-1:0]  i_seed_count,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [sbe_pkg::BIAS_W-1:0]   o_correction_us,
    output logic                                o_accepted,
    output logic                                o_trusted,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [sbe_pkg::ADDR_W-1:0]   paddr,
    input  logic        [sbe_pkg::DATA_W-1:0]   pwdata,
    output logic        [sbe_pkg::DATA_W-1:0]   prdata,
    output logic                                pready
);
    import sbe_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [OCC_W-1:0] FULL = OCC_W'(TABLE_ENTRIES);

    // configuration registers
    logic [LIMIT_W-1:0]   r_bias_limit;
    logic [GAIN_W-1:0]    r_gain;
    logic [COUNT_W-1:0]   r_trust;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // sequencer
    t_state               r_state;
    t_state               n_state;

    // latched request
    logic [OP_W-1:0]      r_op;
    logic [KEY_W-1:0]     r_key;
    logic [BIAS_W-1:0]    r_off;
    logic [TS_W-1:0]      r_ts;
    logic [COUNT_W-1:0]   r_scount;

    // scan
    logic [OCC_W-1:0]     r_occ;
    logic [OCC_W-1:0]     r_issue;
    logic                 r_chk_vld;
    logic [IDX_W-1:0]     r_chk_idx;
    logic                 r_min_vld;
    logic [IDX_W-1:0]     r_min_idx;
    logic [COUNT_W-1:0]   r_min_cnt;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 hit_now;
    logic                 scan_miss;
    logic                 scan_end;
    t_entry               scan_base;

    // entry update
    t_entry               r_mem [TABLE_ENTRIES];
    t_entry               r_rdata;
    t_entry               r_ent;
    t_entry               n_entry;
    logic [IDX_W-1:0]     r_slot;
    logic                 r_alloc;
    logic                 mem_we;
    logic signed [BIAS_W-1:0] blend_bias;

    // result
    logic [BIAS_W-1:0]    r_res_corr;
    logic                 r_res_acc;
    logic                 r_res_tru;
    logic                 r_out_valid;
    logic [BIAS_W-1:0]    r_out_corr;
    logic                 r_out_acc;
    logic                 r_out_tru;
    logic                 done_load;

    // request intake
    logic                 in_acc;
    logic [BIAS_W-1:0]    in_mag;
    logic                 in_ok;
    logic                 in_table_op;

    // ---------------------------------------------------------------- config port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_limit <= RST_BIAS_LIMIT;
            r_gain       <= RST_GAIN;
            r_trust      <= RST_TRUST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BIAS_LIMIT: r_bias_limit <= pwdata[LIMIT_W-1:0];
                REG_GAIN:       r_gain       <= pwdata[GAIN_W-1:0];
                REG_TRUST:      r_trust      <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BIAS_LIMIT: prdata = DATA_W'(r_bias_limit);
            REG_GAIN:       prdata = DATA_W'(r_gain);
            REG_TRUST:      prdata = DATA_W'(r_trust);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- intake
    // one request in flight; a new one is taken only when the sequencer is idle
    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && !o_stall;

    // magnitude of the offset, 2^31 included, checked against the limit
    assign in_mag = i_offset_us[BIAS_W-1] ? (BIAS_W'(0) - $unsigned(i_offset_us))
                                          : $unsigned(i_offset_us);
    assign in_ok  = (in_mag <= {1'b0, r_bias_limit});
    assign in_table_op = (i_operation == OP_QUERY) ||
                         (((i_operation == OP_OBSERVE) || (i_operation == OP_SEED)) && in_ok);

    // ---------------------------------------------------------------- scan
    // read issued at r_issue, key compared in the following cycle on registered data
    assign hit_now   = (r_state == ST_SCAN) && r_chk_vld && (r_rdata.key == r_key);
    assign scan_miss = (r_state == ST_SCAN) && !r_chk_vld && (r_issue == r_occ);
    assign scan_end  = hit_now || scan_miss;
    assign rd_en     = (r_state == ST_SCAN) && (r_issue < r_occ) && !hit_now;
    assign rd_addr   = r_issue[IDX_W-1:0];

    // entry to modify: the hit, or a cleared entry for a new key
    always_comb begin
        if (hit_now) begin
            scan_base = r_rdata;
        end else begin
            scan_base           = '0;
            scan_base.key       = r_key;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = in_table_op ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    if (r_op == OP_QUERY) begin
                        n_state = ST_DONE;
                    end else if ((r_op == OP_OBSERVE) && (scan_base.count != '0)) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_MUL:   n_state = ST_WRITE;
            ST_WRITE: n_state = ST_DONE;
            ST_DONE: begin
                if (done_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    assign done_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign mem_we    = (r_state == ST_WRITE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_issue     <= '0;
            r_chk_vld   <= 1'b0;
            r_min_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_issue   <= '0;
                r_chk_vld <= 1'b0;
                r_min_vld <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_chk_vld <= rd_en;
                if (rd_en) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (r_chk_vld) begin
                    r_min_vld <= 1'b1;
                end
            end
            // a new key written while the table is not full grows the table
            if (mem_we && r_alloc) begin
                r_occ <= r_occ + 1'b1;
            end
            if (done_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_operation;
            r_key      <= i_station_id;
            r_off      <= $unsigned(i_offset_us);
            r_ts       <= i_timestamp_us;
            r_scount   <= i_seed_count;
            r_res_corr <= '0;
            r_res_acc  <= 1'b0;
            r_res_tru  <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            r_chk_idx <= rd_addr;
            // fewest samples, first one kept on ties
            if (r_chk_vld && (!r_min_vld || (r_rdata.count < r_min_cnt))) begin
                r_min_idx <= r_chk_idx;
                r_min_cnt <= r_rdata.count;
            end
        end
        if (scan_end) begin
            r_ent   <= scan_base;
            r_alloc <= !hit_now && (r_occ < FULL);
            if (hit_now) begin
                r_slot <= r_chk_idx;
            end else if (r_occ < FULL) begin
                r_slot <= r_occ[IDX_W-1:0];
            end else begin
                r_slot <= r_min_idx;
            end
            if ((r_op == OP_QUERY) && hit_now && (r_rdata.count >= r_trust)) begin
                r_res_corr <= r_rdata.bias;
                r_res_tru  <= 1'b1;
            end
        end
        if (mem_we) begin
            r_res_acc <= 1'b1;
        end
        if (done_load) begin
            r_out_corr <= r_res_corr;
            r_out_acc  <= r_res_acc;
            r_out_tru  <= r_res_tru;
        end
    end

    // ---------------------------------------------------------------- entry update
    sbe_blend u_blend (
        .i_clk    (i_clk),
        .i_load   (r_state == ST_MUL),
        .i_prev   ($signed(r_ent.bias)),
        .i_offset ($signed(r_off)),
        .i_gain   (r_gain),
        .o_bias   (blend_bias)
    );

    always_comb begin
        n_entry     = r_ent;
        n_entry.key = r_key;
        if (r_op == OP_SEED) begin
            // seed replaces bias and count, last seen stays
            n_entry.bias  = r_off;
            n_entry.count = r_scount;
        end else begin
            n_entry.bias      = (r_ent.count == '0) ? r_off : $unsigned(blend_bias);
            n_entry.count     = (r_ent.count == COUNT_MAX) ? r_ent.count
                                                           : r_ent.count + 1'b1;
            n_entry.last_seen = r_ts;
        end
    end

    // table memory; reads and the write never overlap within a request
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= n_entry;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- result
    assign o_valid         = r_out_valid;
    assign o_correction_us = $signed(r_out_corr);
    assign o_accepted      = r_out_acc;
    assign o_trusted       = r_out_tru;

endmodule
